// ===== src/rau_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rational arithmetic unit package
// Shared constants, opcode and status codes, and sequencer state types.
// ----------------------------------------------------------------------------
package rau_pkg;

    localparam int VALUE_WIDTH_DEF = 32;
    localparam int FIELD_WIDTH     = 32;
    localparam int DEN_WIDTH       = 31;
    localparam int OP_WIDTH        = 4;
    localparam int STATUS_WIDTH    = 2;

    typedef enum logic [OP_WIDTH-1:0] {
        OP_CONSTRUCT = 4'd0,
        OP_NEGATE    = 4'd1,
        OP_FLOOR     = 4'd2,
        OP_CEIL      = 4'd3,
        OP_ROUND     = 4'd4,
        OP_ADD       = 4'd5,
        OP_SUB       = 4'd6,
        OP_MUL       = 4'd7,
        OP_DIV       = 4'd8,
        OP_EQ        = 4'd9,
        OP_NE        = 4'd10,
        OP_LT        = 4'd11,
        OP_LE        = 4'd12,
        OP_GT        = 4'd13,
        OP_GE        = 4'd14
    } t_op;

    typedef enum logic [STATUS_WIDTH-1:0] {
        STATUS_OK       = 2'd0,
        STATUS_ZERO_DEN = 2'd1,
        STATUS_OVERFLOW = 2'd2
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RED,
        S_GCD_WAIT,
        S_DIVN_WAIT,
        S_DIVD_WAIT,
        S_RED_DONE,
        S_EXEC,
        S_INT_WAIT,
        S_ADD_GCD_WAIT,
        S_ADD_DIVB_WAIT,
        S_ADD_DIVD_WAIT,
        S_MUL1,
        S_MUL2,
        S_MUL3,
        S_COMBINE,
        S_DONE
    } t_rau_state;

    typedef enum logic [1:0] {
        PH_A,
        PH_C,
        PH_RES
    } t_phase;

    typedef enum logic [1:0] {
        G_IDLE,
        G_RUN,
        G_SHIFT
    } t_gcd_state;

endpackage

// ===== src/rau_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rational arithmetic unit channels
// Request and response valid/ready channels with their payloads.
// ----------------------------------------------------------------------------
interface rau_req_if;
    import rau_pkg::*;

    logic                          valid;
    logic                          ready;
    logic [OP_WIDTH-1:0]           req_type;
    logic signed [FIELD_WIDTH-1:0] left_num;
    logic signed [FIELD_WIDTH-1:0] left_den;
    logic signed [FIELD_WIDTH-1:0] right_num;
    logic signed [FIELD_WIDTH-1:0] right_den;

    modport source (output valid, req_type, left_num, left_den, right_num, right_den,
                    input ready);
    modport sink   (input valid, req_type, left_num, left_den, right_num, right_den,
                    output ready);
endinterface

interface rau_rsp_if;
    import rau_pkg::*;

    logic                          valid;
    logic                          ready;
    logic signed [FIELD_WIDTH-1:0] result_num;
    logic [DEN_WIDTH-1:0]          result_den;
    logic signed [FIELD_WIDTH-1:0] result_int;
    logic                          result_flag;
    logic [STATUS_WIDTH-1:0]       status;

    modport source (output valid, result_num, result_den, result_int, result_flag, status,
                    input ready);
    modport sink   (input valid, result_num, result_den, result_int, result_flag, status,
                    output ready);
endinterface

// ===== src/rau_divider.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rational arithmetic unit divider
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rau_divider #(
    parameter int WIDTH = 64
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [WIDTH-1:0] i_dividend,
    input  logic [WIDTH-1:0] i_divisor,
    output logic             o_done,
    output logic [WIDTH-1:0] o_quotient
);
    localparam int CW = $clog2(WIDTH + 1);

    logic             r_busy, n_busy;
    logic [CW-1:0]    r_cnt, n_cnt;
    logic [WIDTH-1:0] r_rem, n_rem;
    logic [WIDTH-1:0] r_quo, n_quo;
    logic [WIDTH-1:0] r_dvs, n_dvs;
    logic [WIDTH:0]   sh;
    logic [WIDTH:0]   diff;

    assign o_done     = r_busy && (r_cnt == '0);
    assign o_quotient = r_quo;

    always_comb begin
        sh     = {r_rem, r_quo[WIDTH-1]};
        diff   = sh - {1'b0, r_dvs};
        n_busy = r_busy;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_quo  = r_quo;
        n_dvs  = r_dvs;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = CW'(WIDTH);
            n_rem  = '0;
            n_quo  = i_dividend;
            n_dvs  = i_divisor;
        end else if (r_busy) begin
            if (r_cnt == '0) begin
                n_busy = 1'b0;
            end else begin
                n_cnt = r_cnt - CW'(1);
                if (!diff[WIDTH]) begin
                    n_rem = diff[WIDTH-1:0];
                    n_quo = {r_quo[WIDTH-2:0], 1'b1};
                end else begin
                    n_rem = sh[WIDTH-1:0];
                    n_quo = {r_quo[WIDTH-2:0], 1'b0};
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_cnt  <= n_cnt;
        end
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_dvs <= n_dvs;
    end

    a_no_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> !r_busy || o_done)
        else $error("divider started while busy");

    a_nonzero_divisor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> i_divisor != '0)
        else $error("divider started with zero divisor");

    a_done_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && !i_start |=> !r_busy)
        else $error("divider stays busy after done");

endmodule

// ===== src/rau_gcd.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rational arithmetic unit GCD engine
// Binary GCD, one shift or subtract per cycle, then a bitwise shift back.
// ----------------------------------------------------------------------------
module rau_gcd #(
    parameter int WIDTH = 64
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [WIDTH-1:0] i_a,
    input  logic [WIDTH-1:0] i_b,
    output logic             o_done,
    output logic [WIDTH-1:0] o_g
);
    import rau_pkg::*;

    localparam int KW = $clog2(WIDTH + 1);

    t_gcd_state       r_state, n_state;
    logic [WIDTH-1:0] r_a, n_a;
    logic [WIDTH-1:0] r_b, n_b;
    logic [KW-1:0]    r_k, n_k;

    assign o_done = (r_state == G_SHIFT) && (r_k == '0);
    assign o_g    = r_a;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            G_IDLE:  if (i_start) n_state = G_RUN;
            G_RUN:   if (r_a == '0 || r_b == '0) n_state = G_SHIFT;
            G_SHIFT: if (r_k == '0) n_state = G_IDLE;
            default: n_state = G_IDLE;
        endcase
    end

    always_comb begin
        n_a = r_a;
        n_b = r_b;
        n_k = r_k;
        unique case (r_state)
            G_IDLE: begin
                if (i_start) begin
                    n_a = i_a;
                    n_b = i_b;
                    n_k = '0;
                end
            end
            G_RUN: begin
                priority if (r_a == '0) begin
                    n_a = r_b;
                end else if (r_b == '0) begin
                    n_a = r_a;
                end else if (!r_a[0] && !r_b[0]) begin
                    n_a = r_a >> 1;
                    n_b = r_b >> 1;
                    n_k = r_k + KW'(1);
                end else if (!r_a[0]) begin
                    n_a = r_a >> 1;
                end else if (!r_b[0]) begin
                    n_b = r_b >> 1;
                end else if (r_a >= r_b) begin
                    n_a = r_a - r_b;
                end else begin
                    n_b = r_b - r_a;
                end
            end
            G_SHIFT: begin
                if (r_k != '0) begin
                    n_a = r_a << 1;
                    n_k = r_k - KW'(1);
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= G_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_a <= n_a;
        r_b <= n_b;
        r_k <= n_k;
    end

    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> r_state == G_IDLE)
        else $error("gcd started while busy");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> r_state == G_IDLE)
        else $error("gcd did not return to idle");

    a_run_odd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == G_RUN && r_a != '0 && r_b != '0 && r_a[0] && r_b[0] && r_a >= r_b
        |=> !r_a[0])
        else $error("gcd subtract left an odd value");

endmodule

// ===== src/rational_arithmetic_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rational arithmetic unit
// Sequenced fraction ALU sharing a GCD engine, a divider and a multiplier.
//
// Request beats on i_req carry an opcode and two fractions; each gives one
// response beat on o_rsp with the reduced fraction, the rounded integer, the
// comparison flag and a status code.
// i_req.ready is high only while the sequencer is idle; one request is in
// work at a time. The result waits in an output register, so a new request
// is taken while the previous response is still stalled.
// The sequencer waits on the binary GCD engine (one shift or subtract per
// cycle over 2*VALUE_WIDTH bits, then a shift back by the common factors
// of two) and on the restoring divider; every reduction of a nonzero
// numerator takes one GCD and two divisions. Requests with bad inputs go
// straight to the response.
// If o_rsp stalls, the sequencer holds its finished result until the output
// register frees up.
// Reset clears the sequencer and drops any pending response.
// ----------------------------------------------------------------------------
module rational_arithmetic_unit #(
    parameter int VALUE_WIDTH = rau_pkg::VALUE_WIDTH_DEF
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    rau_req_if.sink   i_req,
    rau_rsp_if.source o_rsp
);
    import rau_pkg::*;

    localparam int VW = VALUE_WIDTH;
    localparam int W2 = 2 * VALUE_WIDTH;
    localparam logic [W2-1:0] HALF = W2'(1) << (VW - 1);

    t_rau_state r_state, n_state;
    t_phase     r_phase, n_phase;
    t_op        r_op, n_op;
    t_status    r_status, n_status;

    logic [W2-1:0] r_rn, n_rn, r_rd, n_rd, r_g, n_g;
    logic          r_rneg, n_rneg;
    logic [VW-1:0] r_an, n_an, r_ad, n_ad, r_cn, n_cn, r_cd, n_cd;
    logic [VW-1:0] r_bb, n_bb, r_dd, n_dd;
    logic          r_aneg, n_aneg, r_cneg, n_cneg;
    logic [W2-1:0] r_p1, n_p1, r_p2, n_p2, r_p3, n_p3;
    logic          r_flag, n_flag;

    logic                   r_ov, n_ov;
    logic [FIELD_WIDTH-1:0] r_o_num, n_o_num, r_o_int, n_o_int;
    logic [DEN_WIDTH-1:0]   r_o_den, n_o_den;
    logic                   r_o_flag, n_o_flag;
    logic [STATUS_WIDTH-1:0] r_o_status, n_o_status;

    logic [VW-1:0] ln_v, ld_v, rn_v, rd_v, ln_m, ld_m, rn_m, rd_m;
    logic          in_err, accept, out_free;

    logic          gcd_start, gcd_done;
    logic [W2-1:0] gcd_a, gcd_b, gcd_g;
    logic          div_start, div_done;
    logic [W2-1:0] div_a, div_b, div_q;

    logic [VW-1:0] mul_a, mul_b;
    logic [W2-1:0] product;

    logic [W2-1:0] an_w, ad_w;
    logic signed [W2-1:0] cmp_l, cmp_r;
    logic [FIELD_WIDTH-1:0] mag32;
    logic          ineg, is_frac, is_int;

    rau_gcd #(.WIDTH(W2)) u_gcd (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (gcd_start),
        .i_a     (gcd_a),
        .i_b     (gcd_b),
        .o_done  (gcd_done),
        .o_g     (gcd_g)
    );

    rau_divider #(.WIDTH(W2)) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_a),
        .i_divisor  (div_b),
        .o_done     (div_done),
        .o_quotient (div_q)
    );

    assign ln_v = i_req.left_num[VW-1:0];
    assign ld_v = i_req.left_den[VW-1:0];
    assign rn_v = i_req.right_num[VW-1:0];
    assign rd_v = i_req.right_den[VW-1:0];
    assign ln_m = ln_v[VW-1] ? (~ln_v + VW'(1)) : ln_v;
    assign ld_m = ld_v[VW-1] ? (~ld_v + VW'(1)) : ld_v;
    assign rn_m = rn_v[VW-1] ? (~rn_v + VW'(1)) : rn_v;
    assign rd_m = rd_v[VW-1] ? (~rd_v + VW'(1)) : rd_v;
    assign in_err = (i_req.req_type > OP_GE) || (ld_m == '0)
                 || ((i_req.req_type >= OP_ADD) && (rd_m == '0));

    assign i_req.ready = (r_state == S_IDLE);
    assign accept      = i_req.valid && (r_state == S_IDLE);
    assign out_free    = !r_ov || o_rsp.ready;

    assign an_w    = W2'(r_an);
    assign ad_w    = W2'(r_ad);
    assign product = W2'(mul_a) * W2'(mul_b);
    assign cmp_l   = r_aneg ? -$signed(r_p1) : $signed(r_p1);
    assign cmp_r   = r_cneg ? -$signed(r_p2) : $signed(r_p2);
    assign mag32   = FIELD_WIDTH'(r_rn);
    assign ineg    = r_rneg && (r_rn != '0);
    assign is_int  = (r_op == OP_FLOOR) || (r_op == OP_CEIL) || (r_op == OP_ROUND);
    assign is_frac = (r_op <= OP_DIV) && !is_int;

    always_comb begin
        unique case (r_state)
            S_MUL1: begin
                unique case (r_op)
                    OP_ADD, OP_SUB: begin mul_a = r_an; mul_b = r_dd; end
                    OP_MUL:         begin mul_a = r_an; mul_b = r_cn; end
                    default:        begin mul_a = r_an; mul_b = r_cd; end
                endcase
            end
            S_MUL2: begin
                unique case (r_op)
                    OP_ADD, OP_SUB: begin mul_a = r_cn; mul_b = r_bb; end
                    OP_MUL:         begin mul_a = r_ad; mul_b = r_cd; end
                    default:        begin mul_a = r_ad; mul_b = r_cn; end
                endcase
            end
            default: begin mul_a = r_bb; mul_b = r_cd; end
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:      if (accept) n_state = in_err ? S_DONE : S_RED;
            S_RED:       n_state = (r_rn == '0) ? S_RED_DONE : S_GCD_WAIT;
            S_GCD_WAIT:  if (gcd_done) n_state = S_DIVN_WAIT;
            S_DIVN_WAIT: if (div_done) n_state = S_DIVD_WAIT;
            S_DIVD_WAIT: if (div_done) n_state = S_RED_DONE;
            S_RED_DONE: begin
                priority case (r_phase)
                    PH_A:    n_state = (r_op >= OP_ADD) ? S_RED : S_EXEC;
                    PH_C:    n_state = S_EXEC;
                    default: n_state = S_DONE;
                endcase
            end
            S_EXEC: begin
                unique case (r_op)
                    OP_CONSTRUCT, OP_NEGATE: n_state = S_DONE;
                    OP_FLOOR, OP_CEIL:       n_state = S_INT_WAIT;
                    OP_ROUND: n_state = (r_aneg && ad_w >= (an_w << 1)) ? S_DONE
                                                                         : S_INT_WAIT;
                    OP_ADD, OP_SUB:          n_state = S_ADD_GCD_WAIT;
                    OP_DIV:   n_state = (r_cn == '0) ? S_DONE : S_MUL1;
                    default:                 n_state = S_MUL1;
                endcase
            end
            S_INT_WAIT:      if (div_done) n_state = S_DONE;
            S_ADD_GCD_WAIT:  if (gcd_done) n_state = S_ADD_DIVB_WAIT;
            S_ADD_DIVB_WAIT: if (div_done) n_state = S_ADD_DIVD_WAIT;
            S_ADD_DIVD_WAIT: if (div_done) n_state = S_MUL1;
            S_MUL1:          n_state = S_MUL2;
            S_MUL2:          n_state = S_MUL3;
            S_MUL3:          n_state = S_COMBINE;
            S_COMBINE:       n_state = (r_op >= OP_EQ) ? S_DONE : S_RED;
            S_DONE:          if (out_free) n_state = S_IDLE;
            default:         n_state = S_IDLE;
        endcase
    end

    // datapath and unit control
    always_comb begin
        n_phase  = r_phase;   n_op   = r_op;   n_status = r_status;
        n_rn     = r_rn;      n_rd   = r_rd;   n_rneg   = r_rneg;   n_g = r_g;
        n_an     = r_an;      n_ad   = r_ad;   n_aneg   = r_aneg;
        n_cn     = r_cn;      n_cd   = r_cd;   n_cneg   = r_cneg;
        n_bb     = r_bb;      n_dd   = r_dd;
        n_p1     = r_p1;      n_p2   = r_p2;   n_p3     = r_p3;    n_flag = r_flag;
        n_ov     = r_ov && !o_rsp.ready;
        n_o_num  = r_o_num;   n_o_den = r_o_den;   n_o_int = r_o_int;
        n_o_flag = r_o_flag;  n_o_status = r_o_status;
        gcd_start = 1'b0; gcd_a = r_rn; gcd_b = r_rd;
        div_start = 1'b0; div_a = r_rn; div_b = gcd_g;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_op     = t_op'(i_req.req_type);
                    n_status = in_err ? STATUS_ZERO_DEN : STATUS_OK;
                    n_rn     = W2'(ln_m);
                    n_rd     = W2'(ld_m);
                    n_rneg   = ln_v[VW-1] ^ ld_v[VW-1];
                    n_cn     = rn_m;
                    n_cd     = rd_m;
                    n_cneg   = rn_v[VW-1] ^ rd_v[VW-1];
                    n_phase  = PH_A;
                end
            end
            S_RED: begin
                if (r_rn == '0) begin
                    n_rneg = 1'b0;
                    n_rd   = W2'(1);
                end else begin
                    gcd_start = 1'b1;
                end
            end
            S_GCD_WAIT: begin
                if (gcd_done) begin
                    n_g       = gcd_g;
                    div_start = 1'b1;
                end
            end
            S_DIVN_WAIT: begin
                if (div_done) begin
                    n_rn      = div_q;
                    div_start = 1'b1;
                    div_a     = r_rd;
                    div_b     = r_g;
                end
            end
            S_DIVD_WAIT: begin
                if (div_done) n_rd = div_q;
            end
            S_RED_DONE: begin
                priority case (r_phase)
                    PH_A: begin
                        n_an   = r_rn[VW-1:0];
                        n_ad   = r_rd[VW-1:0];
                        n_aneg = r_rneg;
                        if (r_op >= OP_ADD) begin
                            n_rn   = W2'(r_cn);
                            n_rd   = W2'(r_cd);
                            n_rneg = r_cneg;
                        end
                        n_phase = PH_C;
                    end
                    PH_C: begin
                        n_cn   = r_rn[VW-1:0];
                        n_cd   = r_rd[VW-1:0];
                        n_cneg = r_rneg;
                        n_rn   = W2'(r_an);
                        n_rd   = W2'(r_ad);
                        n_rneg = r_aneg;
                    end
                    default: ;
                endcase
            end
            S_EXEC: begin
                unique case (r_op)
                    OP_NEGATE: n_rneg = (r_an != '0) ? !r_aneg : 1'b0;
                    OP_FLOOR: begin
                        div_start = 1'b1;
                        div_a = r_aneg ? (an_w + ad_w - W2'(1)) : an_w;
                        div_b = ad_w;
                        n_rneg = r_aneg;
                    end
                    OP_CEIL: begin
                        div_start = 1'b1;
                        div_a = r_aneg ? an_w : (an_w + ad_w - W2'(1));
                        div_b = ad_w;
                        n_rneg = r_aneg;
                    end
                    OP_ROUND: begin
                        div_b = ad_w << 1;
                        if (!r_aneg) begin
                            div_start = 1'b1;
                            div_a  = (an_w << 1) + ad_w;
                            n_rneg = 1'b0;
                        end else if (ad_w >= (an_w << 1)) begin
                            n_rn   = '0;
                            n_rneg = 1'b0;
                        end else begin
                            div_start = 1'b1;
                            div_a  = (an_w << 1) + ad_w - W2'(1);
                            n_rneg = 1'b1;
                        end
                    end
                    OP_ADD, OP_SUB: begin
                        if (r_op == OP_SUB && r_cn != '0) n_cneg = !r_cneg;
                        gcd_start = 1'b1;
                        gcd_a = ad_w;
                        gcd_b = W2'(r_cd);
                    end
                    OP_DIV: begin
                        if (r_cn == '0) n_status = STATUS_ZERO_DEN;
                    end
                    default: ;
                endcase
            end
            S_INT_WAIT: begin
                if (div_done) n_rn = div_q;
            end
            S_ADD_GCD_WAIT: begin
                if (gcd_done) begin
                    n_g       = gcd_g;
                    div_start = 1'b1;
                    div_a     = ad_w;
                end
            end
            S_ADD_DIVB_WAIT: begin
                if (div_done) begin
                    n_bb      = div_q[VW-1:0];
                    div_start = 1'b1;
                    div_a     = W2'(r_cd);
                    div_b     = r_g;
                end
            end
            S_ADD_DIVD_WAIT: begin
                if (div_done) n_dd = div_q[VW-1:0];
            end
            S_MUL1: n_p1 = product;
            S_MUL2: n_p2 = product;
            S_MUL3: n_p3 = product;
            S_COMBINE: begin
                n_phase = PH_RES;
                unique case (r_op)
                    OP_ADD, OP_SUB: begin
                        n_rd = r_p3;
                        priority if (r_aneg == r_cneg) begin
                            n_rneg = r_aneg;  n_rn = r_p1 + r_p2;
                        end else if (r_p1 >= r_p2) begin
                            n_rneg = r_aneg;  n_rn = r_p1 - r_p2;
                        end else begin
                            n_rneg = r_cneg;  n_rn = r_p2 - r_p1;
                        end
                    end
                    OP_MUL, OP_DIV: begin
                        n_rneg = r_aneg ^ r_cneg;
                        n_rn   = r_p1;
                        n_rd   = r_p2;
                    end
                    OP_EQ:   n_flag = (cmp_l == cmp_r);
                    OP_NE:   n_flag = (cmp_l != cmp_r);
                    OP_LT:   n_flag = (cmp_l <  cmp_r);
                    OP_LE:   n_flag = (cmp_l <= cmp_r);
                    OP_GT:   n_flag = (cmp_l >  cmp_r);
                    default: n_flag = (cmp_l >= cmp_r);
                endcase
            end
            S_DONE: begin
                if (out_free) begin
                    n_ov       = 1'b1;
                    n_o_num    = '0;
                    n_o_den    = '0;
                    n_o_int    = '0;
                    n_o_flag   = 1'b0;
                    n_o_status = r_status;
                    if (r_status == STATUS_OK) begin
                        priority if (is_frac) begin
                            if ((r_rneg ? (r_rn > HALF) : (r_rn > HALF - W2'(1)))
                                || (r_rd > HALF - W2'(1))) begin
                                n_o_status = STATUS_OVERFLOW;
                            end else begin
                                n_o_num = r_rneg ? (~mag32 + FIELD_WIDTH'(1)) : mag32;
                                n_o_den = DEN_WIDTH'(r_rd);
                            end
                        end else if (is_int) begin
                            if (ineg ? (r_rn > HALF) : (r_rn > HALF - W2'(1))) begin
                                n_o_status = STATUS_OVERFLOW;
                            end else begin
                                n_o_int = ineg ? (~mag32 + FIELD_WIDTH'(1)) : mag32;
                            end
                        end else begin
                            n_o_flag = r_flag;
                        end
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ov    <= n_ov;
        end
        r_phase <= n_phase;  r_op <= n_op;  r_status <= n_status;
        r_rn <= n_rn;  r_rd <= n_rd;  r_rneg <= n_rneg;  r_g <= n_g;
        r_an <= n_an;  r_ad <= n_ad;  r_aneg <= n_aneg;
        r_cn <= n_cn;  r_cd <= n_cd;  r_cneg <= n_cneg;
        r_bb <= n_bb;  r_dd <= n_dd;
        r_p1 <= n_p1;  r_p2 <= n_p2;  r_p3 <= n_p3;  r_flag <= n_flag;
        r_o_num <= n_o_num;  r_o_den <= n_o_den;  r_o_int <= n_o_int;
        r_o_flag <= n_o_flag;  r_o_status <= n_o_status;
    end

    assign o_rsp.valid       = r_ov;
    assign o_rsp.result_num  = r_o_num;
    assign o_rsp.result_den  = r_o_den;
    assign o_rsp.result_int  = r_o_int;
    assign o_rsp.result_flag = r_o_flag;
    assign o_rsp.status      = r_o_status;

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid && o_rsp.status != STATUS_OK |->
        o_rsp.result_num == '0 && o_rsp.result_den == '0 && o_rsp.result_int == '0
        && !o_rsp.result_flag)
        else $error("error response carries data");

    a_frac_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid && o_rsp.status == STATUS_OK && o_rsp.result_den != '0 |->
        o_rsp.result_int == '0 && !o_rsp.result_flag)
        else $error("fraction response mixes result kinds");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.valid && i_req.ready |=> r_state != S_IDLE)
        else $error("sequencer idle after accepting a request");

    a_units_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(gcd_start && div_start))
        else $error("gcd and divider started together");

endmodule

// ===== verif/rau_tb_types.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rational arithmetic unit testbench types
// Expected response record shared by the testbench top.
// ----------------------------------------------------------------------------
package rau_tb_types;
    import rau_pkg::*;

    typedef struct {
        logic signed [FIELD_WIDTH-1:0] num;
        logic [DEN_WIDTH-1:0]          den;
        logic signed [FIELD_WIDTH-1:0] int_val;
        logic                          flag;
        logic [STATUS_WIDTH-1:0]       status;
    } t_rsp_exp;
endpackage

// ===== verif/rational_arithmetic_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rational arithmetic unit testbench
// Drives opcode/fraction request beats, predicts each response with an
// independent fraction model at 32 bits and compares every response field.
// Both channels idle at random; a long response stall and a drain pause
// exercise the output register and input backpressure.
// ----------------------------------------------------------------------------
module rational_arithmetic_unit_tb;
    import rau_pkg::*;
    import rau_tb_types::*;

    localparam int W = 32;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    rau_req_if req ();
    rau_rsp_if rsp ();

    rational_arithmetic_unit #(.VALUE_WIDTH(W)) uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(req.sink), .o_rsp(rsp.source)
    );

    always #10 i_clk = ~i_clk;

    t_rsp_exp   rsp_queue[$];
    int         mismatch_cnt = 0;
    int         err_cnt = 0;
    bit         quiet_mode = 1'b0;
    int         hold_cycles = 0;

    initial begin
        req.valid = 1'b0;
        req.req_type = '0;
        req.left_num = '0;
        req.left_den = '0;
        req.right_num = '0;
        req.right_den = '0;
        rsp.ready = 1'b0;
    end

    // ---------------- prediction ----------------
    function automatic logic [63:0] gcd_u(logic [63:0] a, logic [63:0] b);
        logic [63:0] t;
        while (b != 0) begin
            t = a % b;
            a = b;
            b = t;
        end
        return a;
    endfunction

    function automatic void reduce_frac(input bit s, input logic [63:0] n,
                                        input logic [63:0] d, output bit rs,
                                        output logic [63:0] rn, output logic [63:0] rd);
        logic [63:0] g;
        if (n == 0) begin
            rs = 0; rn = 0; rd = 1;
        end else begin
            g = gcd_u(n, d);
            rs = s; rn = n / g; rd = d / g;
        end
    endfunction

    function automatic void to_mag(input logic [31:0] v, output bit s, output logic [63:0] m);
        s = v[31];
        m = s ? {32'd0, -v} : {32'd0, v};
        if (s && m == 0) m = 64'h8000_0000;
    endfunction

    function automatic bit fits_int(bit s, logic [63:0] m);
        return s ? (m <= 64'h8000_0000) : (m <= 64'h7FFF_FFFF);
    endfunction

    function automatic void add_frac(input bit as, input logic [63:0] an, input logic [63:0] ad,
                                     input bit cs, input logic [63:0] cn,
                                     input logic [63:0] cd, output bit rs,
                                     output logic [63:0] rn, output logic [63:0] rd);
        logic [63:0] g, bb, dd, t1, t2, den;
        g = gcd_u(ad, cd);
        bb = ad / g;
        dd = cd / g;
        t1 = an * dd;
        t2 = cn * bb;
        den = bb * cd;
        if (as == cs) reduce_frac(as, t1 + t2, den, rs, rn, rd);
        else if (t1 >= t2) reduce_frac(as, t1 - t2, den, rs, rn, rd);
        else reduce_frac(cs, t2 - t1, den, rs, rn, rd);
    endfunction

    function automatic t_rsp_exp predict_rsp(logic [3:0] op, logic [31:0] ln, logic [31:0] ld,
                                             logic [31:0] rn, logic [31:0] rd);
        t_rsp_exp e;
        bit as, cs, s1, s2, ts, flag;
        logic [63:0] an, ad, cn, cd, m1, m2, tn, td, imag;
        logic signed [64:0] lv, rv;
        int kind;
        e = '{num: '0, den: '0, int_val: '0, flag: 1'b0, status: STATUS_OK};
        kind = 0;
        imag = 0;
        flag = 0;
        to_mag(ln, s1, m1);
        to_mag(ld, s2, m2);
        if (op > OP_GE || m2 == 0) begin
            e.status = STATUS_ZERO_DEN;
            return e;
        end
        reduce_frac(s1 != s2, m1, m2, as, an, ad);
        to_mag(rn, s1, m1);
        to_mag(rd, s2, m2);
        if (op >= OP_ADD && m2 == 0) begin
            e.status = STATUS_ZERO_DEN;
            return e;
        end
        reduce_frac(s1 != s2, m1, m2, cs, cn, cd);
        ts = as; tn = an; td = ad;
        case (op)
            OP_CONSTRUCT: ;
            OP_NEGATE: ts = (an != 0) ? !as : 1'b0;
            OP_FLOOR: begin
                kind = 1; ts = as;
                imag = as ? (an + ad - 1) / ad : an / ad;
            end
            OP_CEIL: begin
                kind = 1; ts = as;
                imag = as ? an / ad : (an + ad - 1) / ad;
            end
            OP_ROUND: begin
                kind = 1; ts = 0;
                if (!as) imag = (2 * an + ad) / (2 * ad);
                else if (ad >= 2 * an) imag = 0;
                else begin
                    ts = 1;
                    imag = (2 * an - ad + 2 * ad - 1) / (2 * ad);
                end
            end
            OP_ADD: add_frac(as, an, ad, cs, cn, cd, ts, tn, td);
            OP_SUB: add_frac(as, an, ad, (cn != 0) ? !cs : 1'b0, cn, cd, ts, tn, td);
            OP_MUL: reduce_frac(as != cs, an * cn, ad * cd, ts, tn, td);
            OP_DIV: begin
                if (cn == 0) begin
                    e.status = STATUS_ZERO_DEN;
                    return e;
                end
                reduce_frac(as != cs, an * cd, ad * cn, ts, tn, td);
            end
            default: begin
                kind = 2;
                lv = as ? -$signed({1'b0, an * cd}) : $signed({1'b0, an * cd});
                rv = cs ? -$signed({1'b0, cn * ad}) : $signed({1'b0, cn * ad});
                case (op)
                    OP_EQ: flag = lv == rv;
                    OP_NE: flag = lv != rv;
                    OP_LT: flag = lv < rv;
                    OP_LE: flag = lv <= rv;
                    OP_GT: flag = lv > rv;
                    default: flag = lv >= rv;
                endcase
            end
        endcase
        if (kind == 0) begin
            if (!fits_int(ts, tn) || !fits_int(1'b0, td)) e.status = STATUS_OVERFLOW;
            else begin
                e.num = ts ? -tn[31:0] : tn[31:0];
                e.den = td[30:0];
            end
        end else if (kind == 1) begin
            if (imag == 0) ts = 0;
            if (!fits_int(ts, imag)) e.status = STATUS_OVERFLOW;
            else e.int_val = ts ? -imag[31:0] : imag[31:0];
        end else begin
            e.flag = flag;
        end
        return e;
    endfunction

    // ---------------- driving ----------------
    task automatic send_req(logic [3:0] op, logic [31:0] ln, logic [31:0] ld,
                            logic [31:0] rn, logic [31:0] rd);
        while (!quiet_mode && $urandom_range(99) < 17) begin
            req.valid <= 1'b0;
            @(posedge i_clk);
        end
        req.valid <= 1'b1;
        req.req_type <= op;
        req.left_num <= ln;
        req.left_den <= ld;
        req.right_num <= rn;
        req.right_den <= rd;
        @(posedge i_clk);
        while (!req.ready) @(posedge i_clk);
        rsp_queue.push_back(predict_rsp(op, ln, ld, rn, rd));
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) rsp.ready <= 1'b0;
        else if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            rsp.ready <= 1'b0;
        end else rsp.ready <= quiet_mode ? 1'b1 : ($urandom_range(99) >= 17);
    end

    // ---------------- checking ----------------
    always @(posedge i_clk) begin
        t_rsp_exp e;
        if (i_rst_n && rsp.valid && rsp.ready) begin
            if (rsp_queue.size() == 0) begin
                err_cnt++;
                if (mismatch_cnt++ < 10) $display("unexpected response beat");
            end else begin
                e = rsp_queue.pop_front();
                if (rsp.result_num !== e.num || rsp.result_den !== e.den ||
                    rsp.result_int !== e.int_val || rsp.result_flag !== e.flag ||
                    rsp.status !== e.status) begin
                    err_cnt++;
                    if (mismatch_cnt++ < 10)
                        $display("mismatch exp num=%0d den=%0d int=%0d flag=%0b st=%0d act num=%0d den=%0d int=%0d flag=%0b st=%0d",
                                 e.num, e.den, e.int_val, e.flag, e.status,
                                 rsp.result_num, rsp.result_den, rsp.result_int,
                                 rsp.result_flag, rsp.status);
                end
            end
        end
    end

    task automatic wait_drained();
        req.valid <= 1'b0;
        while (rsp_queue.size() != 0) @(posedge i_clk);
    endtask

    function automatic logic [31:0] rand_val();
        case ($urandom_range(5))
            0: return $urandom_range(20) - 10;
            1: return $urandom_range(1000) - 500;
            2: return $urandom_range(70000) - 35000;
            3: return {$urandom_range(7) == 0, 31'(0)} | $urandom_range(3);
            default: return $urandom;
        endcase
    endfunction

    // ---------------- tests ----------------
    task automatic test_directed();
        t_op op;
        send_req(OP_CONSTRUCT, 6, -4, 0, 0);
        send_req(OP_CONSTRUCT, 0, -7, 0, 0);
        send_req(OP_CONSTRUCT, 5, 0, 0, 0);
        send_req(OP_CONSTRUCT, 0, 0, 0, 0);
        send_req(OP_CONSTRUCT, 32'h8000_0000, 32'hFFFF_FFFF, 0, 0);
        send_req(OP_CONSTRUCT, 1, 32'h8000_0000, 0, 0);
        send_req(OP_NEGATE, 32'h8000_0000, 1, 0, 0);
        send_req(OP_NEGATE, 32'h7FFF_FFFF, 32'h8000_0000, 0, 0);
        send_req(OP_FLOOR, -7, 2, 0, 0);
        send_req(OP_CEIL, -7, 2, 0, 0);
        send_req(OP_CEIL, 7, 2, 0, 0);
        send_req(OP_ROUND, -5, 2, 0, 0);
        send_req(OP_ROUND, 5, 2, 0, 0);
        send_req(OP_ROUND, -1, 3, 0, 0);
        send_req(OP_FLOOR, 32'h8000_0000, -1, 0, 0);
        send_req(OP_ADD, 1, 2, 1, 3);
        send_req(OP_ADD, 32'h7FFF_FFFF, 1, 1, 1);
        send_req(OP_SUB, 1, 2, 1, 2);
        send_req(OP_MUL, 65536, 1, 65536, 1);
        send_req(OP_DIV, 3, 4, 0, 5);
        send_req(OP_DIV, 3, 4, 0, 0);
        send_req(OP_ADD, 1, 2, 1, 0);
        send_req(4'd15, 1, 1, 1, 1);
        for (int i = OP_EQ; i <= OP_GE; i++) begin
            op = t_op'(i);
            send_req(op, 1, 2, -2, -4);
            send_req(op, 32'h8000_0000, 1, 32'h7FFF_FFFF, 32'h8000_0000);
        end
    endtask

    task automatic test_random(int count);
        logic [31:0] ld, rd;
        for (int i = 0; i < count; i++) begin
            ld = rand_val();
            rd = rand_val();
            if ($urandom_range(19) != 0 && ld == 0) ld = 1;
            if ($urandom_range(19) != 0 && rd == 0) rd = 1;
            send_req(4'($urandom_range(15)), rand_val(), ld, rand_val(), rd);
        end
    endtask

    task automatic test_backpressure();
        hold_cycles = 3000;
        for (int i = 0; i < 6; i++) send_req(OP_MUL, rand_val(), 3, rand_val(), 7);
        wait_drained();
        repeat (200) @(posedge i_clk);
        quiet_mode = 1'b1;
        test_random(150);
        quiet_mode = 1'b0;
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random(900);
        test_backpressure();
        test_random(900);
        wait_drained();
        repeat (50) @(posedge i_clk);
        if (err_cnt == 0) $display("PASS rational_arithmetic_unit");
        else $display("FAIL rational_arithmetic_unit");
        $finish;
    end

    initial begin
        #1000ms;
        $display("FAIL rational_arithmetic_unit");
        $finish;
    end
endmodule
